>>> hdl/vila_pkg.sv
`timescale 1ns / 1ps

package vila_pkg;

  // Field widths of one operand word and of one result word.
  localparam int unsigned FuncW   = 4;
  localparam int unsigned OpW     = 17;
  localparam int unsigned AccW    = 33;
  localparam int unsigned ShiftW  = 5;
  localparam int unsigned SatW    = 6;
  localparam int unsigned ResultW = 35;

  // ALU mode codes.
  localparam logic [FuncW-1:0] FUNC_MUL          = 4'd0;
  localparam logic [FuncW-1:0] FUNC_MUL_NEG      = 4'd1;
  localparam logic [FuncW-1:0] FUNC_ADD          = 4'd2;
  localparam logic [FuncW-1:0] FUNC_ADD_NEG      = 4'd3;
  localparam logic [FuncW-1:0] FUNC_SHIFT_SAT    = 4'd4;
  localparam logic [FuncW-1:0] FUNC_MUL_RND      = 4'd5;
  localparam logic [FuncW-1:0] FUNC_MUL_RND_NEG  = 4'd6;
  localparam logic [FuncW-1:0] FUNC_MUL_ALT_A    = 4'd7;
  localparam logic [FuncW-1:0] FUNC_MUL_ALT_B    = 4'd8;
  localparam logic [FuncW-1:0] FUNC_POPCOUNT     = 4'd9;
  localparam logic [FuncW-1:0] FUNC_MUL_NO_ACC   = 4'd10;
  localparam logic [FuncW-1:0] FUNC_PASS_X       = 4'd11;
  localparam logic [FuncW-1:0] FUNC_PASS_Y       = 4'd12;

  // Saturation width limits and the int16 clamp bounds.
  localparam logic [SatW-1:0] SAT_BITS_MIN = 6'd8;
  localparam logic [SatW-1:0] SAT_BITS_MAX = 6'd32;
  localparam logic signed [ResultW:0] CLAMP16_HI = 36'sd32767;
  localparam logic signed [ResultW:0] CLAMP16_LO = -36'sd32768;

  // Number of upper bits of the 64-bit xnor word above the operand width.
  localparam logic [6:0] POP_UPPER_BITS = 7'd47;

  // One operand word as it sits in the input register.
  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [OpW-1:0]    x_val;
    logic [OpW-1:0]    y_val;
    logic [AccW-1:0]   z_val;
    logic [ShiftW-1:0] shift_amount;
    logic              round_enable;
    logic              saturate_enable;
    logic              signed_output;
    logic              signed_z;
    logic [SatW-1:0]   sat_bits;
  } lane_op_t;

endpackage

>>> hdl/vila_alu.sv
`timescale 1ns / 1ps

module vila_alu
  import vila_pkg::*;
(
  input  lane_op_t                   op_i,
  output logic signed [ResultW-1:0] result_o
);

  logic signed [2*OpW-1:0]   prod;
  logic signed [OpW:0]       opsum;
  logic signed [ResultW-1:0] rnd_term;
  logic signed [ResultW-1:0] base;
  logic signed [ResultW-1:0] rounded;
  logic signed [ResultW-1:0] shifted;
  logic signed [ResultW-1:0] negated;
  logic signed [ResultW-1:0] z_ext;
  logic signed [ResultW:0]   acc;
  logic signed [ResultW-1:0] mac_res;
  logic                      is_rnd;
  logic                      is_neg;
  logic                      no_acc;
  logic signed [ResultW-1:0] zr;
  logic signed [ResultW-1:0] zs;
  logic [SatW-1:0]           bits_c;
  logic [SatW-1:0]           bits_b;
  logic signed [ResultW-1:0] sat_hi;
  logic signed [ResultW-1:0] sat_lo;
  logic signed [ResultW-1:0] shsat_res;
  logic [OpW-1:0]            xn;
  logic                      xn_top;
  logic [4:0]                pop_low;
  logic [6:0]                pop_cnt;
  logic signed [ResultW-1:0] pop_res;

  // Shared terms: product, operand sum, rounding half step, extended accumulator.
  assign prod     = $signed(op_i.x_val) * $signed(op_i.y_val);
  assign opsum    = $signed({op_i.x_val[OpW-1], op_i.x_val})
                  + $signed({op_i.y_val[OpW-1], op_i.y_val});
  assign rnd_term = (op_i.shift_amount != '0)
                  ? $signed(35'd1 << (op_i.shift_amount - 5'd1)) : '0;
  assign z_ext    = $signed({{(ResultW-AccW){op_i.z_val[AccW-1]}}, op_i.z_val});

  // Multiply, add and pass modes: select, round, shift, negate, accumulate, clamp.
  always_comb begin
    is_rnd = (op_i.func == FUNC_MUL_RND) || (op_i.func == FUNC_MUL_RND_NEG);
    is_neg = (op_i.func == FUNC_MUL_NEG) || (op_i.func == FUNC_ADD_NEG)
          || (op_i.func == FUNC_MUL_RND_NEG);
    no_acc = (op_i.func == FUNC_MUL_NO_ACC);
    case (op_i.func)
      FUNC_ADD, FUNC_ADD_NEG: begin
        base = $signed({{(ResultW-OpW-1){opsum[OpW]}}, opsum});
      end
      FUNC_PASS_X: begin
        base = $signed({{(ResultW-OpW){op_i.x_val[OpW-1]}}, op_i.x_val});
      end
      FUNC_PASS_Y: begin
        base = $signed({{(ResultW-OpW){op_i.y_val[OpW-1]}}, op_i.y_val});
      end
      default: begin
        base = $signed({{(ResultW-2*OpW){prod[2*OpW-1]}}, prod});
      end
    endcase
    rounded = base + (is_rnd ? rnd_term : '0);
    shifted = rounded >>> op_i.shift_amount;
    negated = is_neg ? -shifted : shifted;
    acc     = $signed({negated[ResultW-1], negated})
            + (no_acc ? '0 : $signed({z_ext[ResultW-1], z_ext}));
    if (is_rnd && (acc > CLAMP16_HI)) begin
      acc = CLAMP16_HI;
    end else if (is_rnd && (acc < CLAMP16_LO)) begin
      acc = CLAMP16_LO;
    end
    mac_res = acc[ResultW-1:0];
  end

  // Shift-saturate of the accumulator.
  always_comb begin
    zr = z_ext + (op_i.round_enable ? rnd_term : '0);
    zs = zr >>> op_i.shift_amount;
    if (op_i.sat_bits < SAT_BITS_MIN) begin
      bits_c = SAT_BITS_MIN;
    end else if (op_i.sat_bits > SAT_BITS_MAX) begin
      bits_c = SAT_BITS_MAX;
    end else begin
      bits_c = op_i.sat_bits;
    end
    bits_b = bits_c - {{(SatW-1){1'b0}}, op_i.signed_output};
    sat_hi = $signed(35'd1 << bits_b);
    sat_lo = op_i.signed_output ? -sat_hi : '0;
    shsat_res = zs;
    if (op_i.saturate_enable) begin
      if (op_i.signed_z) begin
        if (zs < sat_lo) begin
          shsat_res = sat_lo;
        end else if (zs >= sat_hi) begin
          shsat_res = sat_hi - 35'sd1;
        end
      end else if ((zs < 35'sd0) || (zs >= sat_hi)) begin
        // A negative value reads as a huge unsigned one and clamps to the top.
        shsat_res = sat_hi - 35'sd1;
      end
    end
  end

  // Popcount of the xnor word: the bits above the operand width all equal
  // the xnor of the sign bits, and the left shift only drops upper bits.
  always_comb begin
    xn      = ~(op_i.x_val ^ op_i.y_val);
    xn_top  = xn[OpW-1];
    pop_low = '0;
    for (int i = 0; i < OpW; i++) begin
      pop_low = pop_low + {4'd0, xn[i]};
    end
    pop_cnt = {2'd0, pop_low}
            + (xn_top ? (POP_UPPER_BITS - {2'd0, op_i.shift_amount}) : 7'd0);
    pop_res = z_ext + $signed({{(ResultW-7){1'b0}}, pop_cnt});
  end

  // Final mode selection.
  always_comb begin
    case (op_i.func)
      FUNC_SHIFT_SAT: result_o = shsat_res;
      FUNC_POPCOUNT:  result_o = pop_res;
      default:        result_o = mac_res;
    endcase
  end

endmodule

>>> hdl/vector_integer_lane_alu_core.sv
`timescale 1ns / 1ps
// Stages: the input register and then the result register, so two register
// stages from input pins to result pins. Throughput: one word per cycle while
// out_stall_i holds no result; the input and result registers form a two-deep
// pipeline; a new word enters while a result waits if the input stage is empty.
// Reset: rst_ni clears both stage valid flags asynchronously; no state besides.

module vector_integer_lane_alu_core
  import vila_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [FuncW-1:0]          func_i,
  input  logic signed [OpW-1:0]     x_val_i,
  input  logic signed [OpW-1:0]     y_val_i,
  input  logic signed [AccW-1:0]    z_val_i,
  input  logic [ShiftW-1:0]         shift_amount_i,
  input  logic                      round_enable_i,
  input  logic                      saturate_enable_i,
  input  logic                      signed_output_i,
  input  logic                      signed_z_i,
  input  logic [SatW-1:0]           sat_bits_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [ResultW-1:0] result_o
);

  logic                      s1_valid_q, s1_valid_d;
  logic                      out_valid_q, out_valid_d;
  lane_op_t                  op_q;
  logic signed [ResultW-1:0] result_q;
  logic signed [ResultW-1:0] alu_result;
  logic                      s1_load;
  logic                      out_free;
  logic                      out_load;

  // Handshake control: the result register frees when empty or taken.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_comb begin
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (out_free) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register holds the accepted word.
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      op_q.func            <= func_i;
      op_q.x_val           <= x_val_i;
      op_q.y_val           <= y_val_i;
      op_q.z_val           <= z_val_i;
      op_q.shift_amount    <= shift_amount_i;
      op_q.round_enable    <= round_enable_i;
      op_q.saturate_enable <= saturate_enable_i;
      op_q.signed_output   <= signed_output_i;
      op_q.signed_z        <= signed_z_i;
      op_q.sat_bits        <= sat_bits_i;
    end
  end

  vila_alu u_alu (
    .op_i     (op_q),
    .result_o (alu_result)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_q <= alu_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

`ifndef NO_ASSERTIONS
  // A stalled input side means both stages are full and the output is held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full, stalled pipeline");

  // A word in the input stage with a free result register moves on.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_free) |=> out_valid_q)
    else $error("input stage word did not reach the result register");

  // Rounded multiply modes always land inside the int16 range.
  a_clamp16: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && ((op_q.func == FUNC_MUL_RND) || (op_q.func == FUNC_MUL_RND_NEG)))
    |=> ((result_o <= 35'sd32767) && (result_o >= -35'sd32768)))
    else $error("rounded multiply result outside the int16 range");
`endif

endmodule
